/* src/trgm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the trackpad gesture report mapper.
// Used by every module of the block; depends on nothing.
package trgm_pkg;

	localparam int WHEEL_STEP_DEF = 32;
	localparam int DELTA_W        = 16;
	localparam int ACC_W          = 17;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int IN_TDATA_W     = 40;
	localparam int OUT_TDATA_W    = 24;

	localparam logic [CFG_IDX_W-1:0] REG_INV_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd2;

	localparam logic [CFG_DATA_W-1:0] DELAY_RST = 16'd100;

	localparam logic OP_TICK  = 1'b1;
	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_REL = 1'b1;

	localparam logic [1:0] CODE_LEFT   = 2'd0;
	localparam logic [1:0] CODE_RIGHT  = 2'd1;
	localparam logic [1:0] CODE_X      = 2'd0;
	localparam logic [1:0] CODE_Y      = 2'd1;
	localparam logic [1:0] CODE_WHEEL  = 2'd2;
	localparam logic [1:0] CODE_HWHEEL = 2'd3;

	typedef struct packed {
		logic                      opcode;
		logic                      tap_one;
		logic                      tap_two;
		logic                      hold_flag;
		logic                      scroll_flag;
		logic                      zoom_flag;
		logic                      movement_flag;
		logic                      palm_flag;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
	} item_t;

	typedef struct packed {
		logic               neg;
		logic               zero;
		logic [DELTA_W-1:0] q;
	} axis_t;

	typedef struct packed {
		logic                      kind;
		logic [1:0]                code;
		logic signed [DELTA_W-1:0] value;
		logic                      sync;
	} report_t;

	typedef struct packed {
		logic [1:0] count;
		report_t    rep1;
		report_t    rep0;
	} result_t;

endpackage

/* src/trgm_div_pipe.sv */
`timescale 1ns / 1ps
// Input pipeline: registers the incoming word and splits the scroll deltas
// into magnitude quotient and remainder by the scroll divisor. Uses trgm_pkg.
module trgm_div_pipe import trgm_pkg::*; #(
	parameter int WHEEL_STEP = WHEEL_STEP_DEF,
	localparam int REM_W = $clog2(WHEEL_STEP)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  item_t                  in_item,
	input  logic                   inv_x,
	input  logic                   inv_y,
	input  logic                   adv,
	output logic                   out_valid,
	output item_t                  out_item,
	output axis_t [1:0]            out_axis,
	output logic [1:0][REM_W-1:0]  out_rem
);

	localparam int SHIFT   = DELTA_W + REM_W;
	localparam int MAG_W   = DELTA_W + 1;
	localparam int RECIP_W = DELTA_W + 1;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam int DIV_W   = REM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WHEEL_STEP) - 64'd1) / 64'(WHEEL_STEP));
	localparam logic [DIV_W-1:0] DIV_C = DIV_W'(WHEEL_STEP);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	item_t item_s1, item_s2, item_s3;

	logic [1:0]               neg_ctl;
	logic [1:0]               neg_c, zero_c;
	logic [1:0][MAG_W-1:0]    mag_c;
	logic [1:0][PROD_W-1:0]   prod_c;
	logic [1:0][DELTA_W-1:0]  q_c;
	logic [1:0][MAG_W-1:0]    qd_c;

	logic [1:0]               neg_s2, zero_s2, neg_s3, zero_s3;
	logic [1:0][MAG_W-1:0]    mag_s2, mag_s3, qd_s3;
	logic [1:0][DELTA_W-1:0]  q_s3;
	logic [1:0][PROD_W-1:0]   prod_s2;

	assign en3      = !v_s3 || adv;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign neg_ctl  = {inv_y, !inv_x};

	always_comb begin
		logic signed [DELTA_W-1:0] d;
		logic signed [DELTA_W:0]   e;
		logic                      gate;
		gate = item_s1.movement_flag || item_s1.scroll_flag;
		for (int i = 0; i < 2; i++) begin
			d = (i == 0) ? item_s1.delta_x : item_s1.delta_y;
			if (!gate)
				d = '0;
			e = {d[DELTA_W-1], d};
			if (neg_ctl[i])
				e = -e;
			neg_c[i]  = e[DELTA_W];
			zero_c[i] = (d == '0);
			mag_c[i]  = MAG_W'(e[DELTA_W] ? -e : e);
			prod_c[i] = PROD_W'(mag_c[i]) * PROD_W'(RECIP);
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			q_c[i]  = DELTA_W'(prod_s2[i] >> SHIFT);
			qd_c[i] = MAG_W'(q_c[i]) * MAG_W'(DIV_C);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1)
			item_s1 <= in_item;
		if (en2) begin
			item_s2 <= item_s1;
			neg_s2  <= neg_c;
			zero_s2 <= zero_c;
			mag_s2  <= mag_c;
			prod_s2 <= prod_c;
		end
		if (en3) begin
			item_s3 <= item_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			mag_s3  <= mag_s2;
			q_s3    <= q_c;
			qd_s3   <= qd_c;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			out_axis[i].neg  = neg_s3[i];
			out_axis[i].zero = zero_s3[i];
			out_axis[i].q    = q_s3[i];
			out_rem[i]       = REM_W'(mag_s3[i] - qd_s3[i]);
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

/* src/trgm_gesture.sv */
`timescale 1ns / 1ps
// Gesture state and report selection: hold, tap and release countdown,
// scroll accumulators and movement. Uses trgm_pkg; fed by trgm_div_pipe.
module trgm_gesture import trgm_pkg::*; #(
	parameter int WHEEL_STEP = WHEEL_STEP_DEF,
	localparam int REM_W = $clog2(WHEEL_STEP)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  item_t                 item,
	input  axis_t [1:0]           axis,
	input  logic [1:0][REM_W-1:0] rem,
	input  logic                  commit,
	input  logic [DELTA_W-1:0]    release_delay,
	output result_t               result
);

	localparam int SUM_W = REM_W + 2;
	localparam logic signed [SUM_W-1:0] DIV_S = SUM_W'(WHEEL_STEP);

	logic signed [ACC_W-1:0] acc_q [2];
	logic signed [ACC_W-1:0] acc_n [2];
	logic                    tap_q, two_q, hold_q, armed_q;
	logic                    tap_n, two_n, hold_n, armed_n;
	logic [DELTA_W-1:0]      count_q, count_n;

	logic [1:0]                     lane_rep;
	logic signed [1:0][DELTA_W-1:0] lane_val;
	logic signed [ACC_W-1:0]        lane_acc [2];

	function automatic report_t mk(input logic kind, input logic [1:0] code,
			input logic signed [DELTA_W-1:0] value, input logic sync);
		report_t r;
		r.kind  = kind;
		r.code  = code;
		r.value = value;
		r.sync  = sync;
		return r;
	endfunction

	always_comb begin
		logic signed [SUM_W-1:0] rs;
		logic signed [SUM_W-1:0] s;
		logic signed [ACC_W-1:0] a;
		for (int i = 0; i < 2; i++) begin
			rs = $signed({2'b00, rem[i]});
			if (axis[i].neg)
				rs = -rs;
			s = rs + SUM_W'(acc_q[i]);
			a = $signed({1'b0, axis[i].q});
			if (axis[i].neg)
				a = -a;
			if (s < 0) begin
				s = s + DIV_S;
				a = a - 17'sd1;
			end
			if (s < 0) begin
				s = s + DIV_S;
				a = a - 17'sd1;
			end
			if (s >= DIV_S) begin
				s = s - DIV_S;
				a = a + 17'sd1;
			end
			// floor to truncation toward zero
			if (a < 0 && s != 0) begin
				a = a + 17'sd1;
				s = s - DIV_S;
			end
			lane_rep[i] = (a != '0);
			lane_val[i] = DELTA_W'(a);
			lane_acc[i] = ACC_W'(s);
		end
	end

	always_comb begin
		logic tap_ok, press_l, press_r, hx, wh;
		acc_n[0] = acc_q[0];
		acc_n[1] = acc_q[1];
		tap_n    = tap_q;
		two_n    = two_q;
		hold_n   = hold_q;
		armed_n  = armed_q;
		count_n  = count_q;
		result   = '0;
		tap_ok   = !(item.scroll_flag && item.zoom_flag);
		press_l  = item.tap_one && tap_ok;
		press_r  = !press_l && item.tap_two && tap_ok;
		hx       = !axis[0].zero && lane_rep[0];
		wh       = !axis[1].zero && lane_rep[1];
		if (item.opcode == OP_TICK) begin
			if (armed_q) begin
				if (count_q > 16'd1) begin
					count_n = count_q - 16'd1;
				end else begin
					armed_n      = 1'b0;
					count_n      = '0;
					tap_n        = 1'b0;
					two_n        = 1'b0;
					result.count = 2'(tap_q) + 2'(two_q);
					result.rep0  = mk(KIND_KEY, tap_q ? CODE_LEFT : CODE_RIGHT, 16'sd0, 1'b1);
					result.rep1  = mk(KIND_KEY, CODE_RIGHT, 16'sd0, 1'b1);
				end
			end
		end else begin
			if (!item.scroll_flag) begin
				acc_n[0] = '0;
				acc_n[1] = '0;
			end
			if (press_l)
				tap_n = 1'b1;
			if (press_r)
				two_n = 1'b1;
			if (item.hold_flag && !hold_q) begin
				hold_n       = 1'b1;
				result.count = 2'd1;
				result.rep0  = mk(KIND_KEY, CODE_LEFT, 16'sd1, 1'b1);
			end else if (!item.hold_flag && hold_q) begin
				hold_n       = 1'b0;
				result.count = 2'd1;
				result.rep0  = mk(KIND_KEY, CODE_LEFT, 16'sd0, 1'b1);
			end else if (press_l || press_r) begin
				armed_n      = 1'b1;
				count_n      = release_delay;
				result.count = 2'd1;
				result.rep0  = mk(KIND_KEY, press_l ? CODE_LEFT : CODE_RIGHT, 16'sd1, 1'b1);
			end else if (item.scroll_flag) begin
				if (!axis[0].zero)
					acc_n[0] = lane_acc[0];
				if (!axis[1].zero)
					acc_n[1] = lane_acc[1];
				result.count = 2'(hx) + 2'(wh);
				result.rep0  = hx ? mk(KIND_REL, CODE_HWHEEL, lane_val[0], 1'b1)
					: mk(KIND_REL, CODE_WHEEL, lane_val[1], 1'b1);
				result.rep1  = mk(KIND_REL, CODE_WHEEL, lane_val[1], 1'b1);
			end else if (item.movement_flag && !item.palm_flag) begin
				if (item.delta_x != '0 || item.delta_y != '0) begin
					result.count = 2'd2;
					result.rep0  = mk(KIND_REL, CODE_X, item.delta_x, 1'b0);
					result.rep1  = mk(KIND_REL, CODE_Y, item.delta_y, 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			tap_q    <= 1'b0;
			two_q    <= 1'b0;
			hold_q   <= 1'b0;
			armed_q  <= 1'b0;
			count_q  <= '0;
		end else if (in_valid && commit) begin
			acc_q[0] <= acc_n[0];
			acc_q[1] <= acc_n[1];
			tap_q    <= tap_n;
			two_q    <= two_n;
			hold_q   <= hold_n;
			armed_q  <= armed_n;
			count_q  <= count_n;
		end
	end

endmodule

/* src/trgm_out_reg.sv */
`timescale 1ns / 1ps
// Result register: holds up to two reports of one item and sends them
// one word per cycle while m_ready is high. Uses trgm_pkg.
module trgm_out_reg import trgm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t result,
	output logic    take,
	output logic    m_valid,
	input  logic    m_ready,
	output report_t word,
	output logic    m_last
);

	logic    valid_q, second_q, two_q;
	report_t rep0_q, rep1_q;

	assign m_last  = second_q || !two_q;
	assign take    = !valid_q || (m_ready && m_last);
	assign m_valid = valid_q;
	assign word    = second_q ? rep1_q : rep0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
			two_q    <= 1'b0;
		end else if (take) begin
			valid_q  <= in_valid && (result.count != 2'd0);
			second_q <= 1'b0;
			two_q    <= result.count[1];
		end else if (m_ready) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rep0_q <= result.rep0;
			rep1_q <= result.rep1;
		end
	end

endmodule

/* src/trackpad_gesture_report_mapper.sv */
`timescale 1ns / 1ps
// Top level of the trackpad gesture report mapper: configuration registers,
// word packing and the pipeline. Uses trgm_pkg, trgm_div_pipe, trgm_gesture, trgm_out_reg.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | frame or tick word, kind in s_tuser
//  m_*     | out       | m_tvalid/m_tready  | key or relative report, m_tlast per item
//  cfg_*   | in        | cfg_we             | register index and data, no read-back
//
// One word is accepted per cycle while the result register takes each item; a word
// passes the s1, s2 and s3 stages of trgm_div_pipe and then the result register.
// An item with two reports holds the result register until its second is sent.
// The scroll divide is a reciprocal multiply and a product-by-divisor stage.
// arst_n clears the pipeline, gesture state and registers to their defaults.
// m_tready low holds the result register and stalls the pipeline behind it.
module trackpad_gesture_report_mapper import trgm_pkg::*; #(
	parameter int WHEEL_STEP = WHEEL_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// tap_one, tap_two, hold_flag, scroll_flag, zoom_flag,
	// movement_flag, palm_flag, delta_x[15:0], delta_y[15:0], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// report_code[1:0], report_value[15:0], sync, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// report_kind
	output logic                   m_tuser,
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int REM_W = $clog2(WHEEL_STEP);

	logic                  inv_x_q, inv_y_q;
	logic [DELTA_W-1:0]    delay_q;
	item_t                 in_item, p_item;
	logic                  p_valid, take;
	axis_t [1:0]           p_axis;
	logic [1:0][REM_W-1:0] p_rem;
	result_t               result;
	report_t               word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= 1'b0;
			inv_y_q <= 1'b0;
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_X: inv_x_q <= cfg_data[0];
				REG_INV_Y: inv_y_q <= cfg_data[0];
				REG_DELAY: delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item.opcode         = s_tuser;
	assign in_item.tap_one        = s_tdata[0];
	assign in_item.tap_two        = s_tdata[1];
	assign in_item.hold_flag      = s_tdata[2];
	assign in_item.scroll_flag    = s_tdata[3];
	assign in_item.zoom_flag      = s_tdata[4];
	assign in_item.movement_flag  = s_tdata[5];
	assign in_item.palm_flag      = s_tdata[6];
	assign in_item.delta_x        = s_tdata[22:7];
	assign in_item.delta_y        = s_tdata[38:23];

	trgm_div_pipe #(.WHEEL_STEP(WHEEL_STEP)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.inv_x    (inv_x_q),
		.inv_y    (inv_y_q),
		.adv      (take),
		.out_valid(p_valid),
		.out_item (p_item),
		.out_axis (p_axis),
		.out_rem  (p_rem)
	);

	trgm_gesture #(.WHEEL_STEP(WHEEL_STEP)) u_gesture (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (p_valid),
		.item         (p_item),
		.axis         (p_axis),
		.rem          (p_rem),
		.commit       (take),
		.release_delay(delay_q),
		.result       (result)
	);

	trgm_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(p_valid),
		.result  (result),
		.take    (take),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.word    (word),
		.m_last  (m_tlast)
	);

	assign m_tdata = {5'b0, word.sync, word.value, word.code};
	assign m_tuser = word.kind;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_pair_completes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("second report of a pair missing");

	a_key_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_KEY) |-> word.sync)
		else $error("key report without sync");

	a_x_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_REL) && (word.code == CODE_X) |-> !m_tlast)
		else $error("x movement report not followed by y");

endmodule

/* test/trackpad_gesture_report_mapper_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for trackpad_gesture_report_mapper: directed and random frames
// and ticks, checked report by report against a behavioral predictor. Depends on trgm_pkg.
module trackpad_gesture_report_mapper_tb;
	import trgm_pkg::*;

	localparam logic           OP_FRAME      = 1'b0;
	localparam logic [1:0]     REG_UNUSED    = 2'd3;
	localparam int             SCROLL_STEP   = WHEEL_STEP_DEF;
	localparam int             HOLDOFF_LEN   = 300;
	localparam int             QUIET_LIMIT   = 20000;
	localparam int             SETTLE_CYCLES = 8;

	typedef struct packed {
		logic        kind;
		logic [1:0]  code;
		logic [15:0] value;
		logic        sync;
		logic        last;
	} mapped_report_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// predictor state and register copies
	int          acc_x, acc_y;
	logic        tap_pend, two_tap_pend, hold_on, rel_armed;
	logic [15:0] rel_count;
	logic        inv_x, inv_y;
	logic [15:0] rel_delay;

	mapped_report_t expected_reports[$];
	mapped_report_t want, got;

	int err_count      = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int holdoff_req    = 0;
	int holdoff_seen   = 0;
	int holdoff_left   = 0;
	int scroll_run_left = 0;
	logic hold_level   = 1'b0;

	trackpad_gesture_report_mapper DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void push_report(logic kind, logic [1:0] code, logic [15:0] value,
			logic sync);
		mapped_report_t r;
		r = '{kind, code, value, sync, 1'b0};
		expected_reports.push_back(r);
	endfunction

	function automatic void map_item(item_t it);
		int             base, dx, dy;
		logic           pressed, tap_ok;
		logic [1:0]     key;
		mapped_report_t r;
		base = expected_reports.size();
		if (it.opcode == OP_TICK) begin
			if (rel_armed) begin
				if (rel_count > 16'd1) begin
					rel_count = rel_count - 16'd1;
				end else begin
					rel_armed = 1'b0;
					rel_count = '0;
					if (tap_pend) begin
						push_report(KIND_KEY, CODE_LEFT, 16'd0, 1'b1);
						tap_pend = 1'b0;
					end
					if (two_tap_pend) begin
						push_report(KIND_KEY, CODE_RIGHT, 16'd0, 1'b1);
						two_tap_pend = 1'b0;
					end
				end
			end
		end else begin
			dx = 0;
			dy = 0;
			if (it.movement_flag || it.scroll_flag) begin
				dx = $signed(it.delta_x);
				dy = $signed(it.delta_y);
			end
			if (!it.scroll_flag) begin
				acc_x = 0;
				acc_y = 0;
			end
			pressed = 1'b0;
			key = CODE_LEFT;
			tap_ok = !(it.scroll_flag && it.zoom_flag);
			if (it.tap_one && tap_ok) begin
				pressed = 1'b1;
				tap_pend = 1'b1;
				key = CODE_LEFT;
			end else if (it.tap_two && tap_ok) begin
				pressed = 1'b1;
				two_tap_pend = 1'b1;
				key = CODE_RIGHT;
			end
			if (it.hold_flag && !hold_on) begin
				push_report(KIND_KEY, CODE_LEFT, 16'd1, 1'b1);
				hold_on = 1'b1;
			end else if (!it.hold_flag && hold_on) begin
				push_report(KIND_KEY, CODE_LEFT, 16'd0, 1'b1);
				hold_on = 1'b0;
			end else if (pressed) begin
				push_report(KIND_KEY, key, 16'd1, 1'b1);
				rel_armed = 1'b1;
				rel_count = rel_delay;
			end else if (it.scroll_flag) begin
				if (dx != 0) begin
					if (!inv_x)
						dx = -dx;
					acc_x += dx;
					if (acc_x >= SCROLL_STEP || acc_x <= -SCROLL_STEP) begin
						push_report(KIND_REL, CODE_HWHEEL, 16'(acc_x / SCROLL_STEP), 1'b1);
						acc_x = acc_x % SCROLL_STEP;
					end
				end
				if (dy != 0) begin
					if (inv_y)
						dy = -dy;
					acc_y += dy;
					if (acc_y >= SCROLL_STEP || acc_y <= -SCROLL_STEP) begin
						push_report(KIND_REL, CODE_WHEEL, 16'(acc_y / SCROLL_STEP), 1'b1);
						acc_y = acc_y % SCROLL_STEP;
					end
				end
			end else if (it.movement_flag && !it.palm_flag) begin
				if (dx != 0 || dy != 0) begin
					push_report(KIND_REL, CODE_X, 16'(dx), 1'b0);
					push_report(KIND_REL, CODE_Y, 16'(dy), 1'b1);
				end
			end
		end
		if (expected_reports.size() > base) begin
			r = expected_reports.pop_back();
			r.last = 1'b1;
			expected_reports.push_back(r);
		end
	endfunction

	function automatic item_t make_frame(logic stap, logic ttap, logic hold, logic scroll,
			logic zoom, logic move, logic palm, logic [15:0] dx, logic [15:0] dy);
		item_t it;
		it = '{OP_FRAME, stap, ttap, hold, scroll, zoom, move, palm, dx, dy};
		return it;
	endfunction

	function automatic item_t make_tick();
		item_t it;
		it = '0;
		it.opcode = OP_TICK;
		return it;
	endfunction

	function automatic logic [15:0] random_delta();
		logic [15:0] d;
		case ($urandom_range(9))
			7, 8: d = 16'($urandom);
			9: begin
				case ($urandom_range(3))
					0: d = 16'h8000;
					1: d = 16'h7FFF;
					2: d = 16'hFFFF;
					default: d = 16'h0000;
				endcase
			end
			default: d = 16'($urandom_range(128) - 64);
		endcase
		return d;
	endfunction

	function automatic item_t random_item();
		item_t       it;
		logic [63:0] noise;
		if (scroll_run_left == 0 && $urandom_range(99) < 8)
			scroll_run_left = $urandom_range(10, 3);
		if ($urandom_range(99) < 30) begin
			noise = {$urandom, $urandom};
			it = noise[IN_TDATA_W-1:0];
			it.opcode = OP_TICK;
		end else if (scroll_run_left > 0) begin
			scroll_run_left--;
			it = make_frame($urandom_range(99) < 5, $urandom_range(99) < 5, hold_level, 1'b1,
				$urandom_range(9) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
				random_delta(), random_delta());
		end else begin
			if ($urandom_range(99) < 10)
				hold_level = !hold_level;
			it = make_frame($urandom_range(99) < 10, $urandom_range(99) < 10, hold_level,
				$urandom_range(99) < 20, $urandom_range(99) < 25, $urandom_range(99) < 60,
				$urandom_range(99) < 15, random_delta(), random_delta());
		end
		return it;
	endfunction

	task automatic offer_word(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.delta_y, it.delta_x, it.palm_flag, it.movement_flag,
			it.zoom_flag, it.scroll_flag, it.hold_flag, it.tap_two, it.tap_one};
		s_tuser  <= it.opcode;
		map_item(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_INV_X: inv_x = val[0];
			REG_INV_Y: inv_y = val[0];
			REG_DELAY: rel_delay = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_tap_release();
		write_reg(REG_DELAY, 16'd2);
		offer_word(make_frame(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_tick());
		offer_word(make_tick());
		offer_word(make_frame(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_tick());
		offer_word(make_tick());
	endtask

	task automatic test_pointer_scroll();
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd5, 16'd0));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 16'h7FFF));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'h8000));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 16'd1));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, -16'sd20, 16'h0));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd20, 16'h0));
	endtask

	task automatic test_inverted_zero_delay();
		drain_reports();
		write_reg(REG_INV_X, 16'd1);
		write_reg(REG_INV_Y, 16'd1);
		write_reg(REG_DELAY, 16'd0);
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'h8000, 16'h8000));
		offer_word(make_frame(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_tick());
		offer_word(make_tick());
		drain_reports();
		// an unused index must leave every register alone
		write_reg(REG_UNUSED, 16'hFFFF);
		offer_word(make_frame(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_tick());
	endtask

	task automatic test_random_traffic(input int count);
		int left, seg;
		left = count;
		while (left > 0) begin
			drain_reports();
			write_reg(REG_INV_X, 16'($urandom_range(1)));
			write_reg(REG_INV_Y, 16'($urandom_range(1)));
			case ($urandom_range(5))
				0: write_reg(REG_DELAY, 16'd0);
				1: write_reg(REG_DELAY, 16'd1);
				default: write_reg(REG_DELAY, 16'($urandom_range(12, 2)));
			endcase
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, 16'($urandom));
			seg = (left < 50) ? left : 50;
			repeat (seg) offer_word(random_item());
			left -= seg;
		end
	endtask

	task automatic test_backpressure();
		int saved;
		saved = send_idle_pct;
		send_idle_pct = 0;
		holdoff_req++;
		repeat (40)
			offer_word(make_frame(1'b0, 1'b0, hold_level, 1'b0, 1'b0, 1'b1, 1'b0,
				16'($urandom) | 16'd1, 16'($urandom)));
		// hold the sender until the queue runs dry, then resume
		drain_reports();
		repeat (10) offer_word(random_item());
		send_idle_pct = saved;
	endtask

	task automatic test_longest_release();
		drain_reports();
		write_reg(REG_DELAY, 16'hFFFF);
		offer_word(make_frame(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		offer_word(make_frame(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		repeat (24) offer_word(make_tick());
		drain_reports();
		// re-arm a running countdown with a short delay
		write_reg(REG_DELAY, 16'd25);
		offer_word(make_frame(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
		repeat (25) offer_word(make_tick());
		hold_level = 1'b0;
	endtask

	always @(posedge clk) begin
		if (holdoff_req != holdoff_seen) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_LEN;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[1:0], m_tdata[17:2], m_tdata[18], m_tlast};
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report kind %0d code %0d value %0d sync %0d last %0d",
					$time, got.kind, got.code, $signed(got.value), got.sync, got.last);
				err_count++;
			end else begin
				want = expected_reports.pop_front();
				if (got != want || m_tdata[OUT_TDATA_W-1:19] != '0) begin
					$display("%0t: expected kind %0d code %0d value %0d sync %0d last %0d pad 0",
						$time, want.kind, want.code, $signed(want.value), want.sync, want.last);
					$display("%0t: actual   kind %0d code %0d value %0d sync %0d last %0d pad %0h",
						$time, got.kind, got.code, $signed(got.value), got.sync, got.last,
						m_tdata[OUT_TDATA_W-1:19]);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: timeout, %0d reports still expected", $time, expected_reports.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		acc_x        = 0;
		acc_y        = 0;
		tap_pend     = 1'b0;
		two_tap_pend = 1'b0;
		hold_on      = 1'b0;
		rel_armed    = 1'b0;
		rel_count    = '0;
		inv_x        = 1'b0;
		inv_y        = 1'b0;
		rel_delay    = DELAY_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 80;
		test_tap_release();
		test_pointer_scroll();
		test_inverted_zero_delay();
		test_random_traffic(190);

		send_idle_pct = 80;
		recv_idle_pct = 26;
		test_random_traffic(190);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_longest_release();
		test_random_traffic(190);

		drain_reports();
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
